FILE: rtl/core/kti_pkg.sv
// Shared types and codes of the keyframe track interpolator.
package kti_pkg;

  // Item kinds
  localparam logic [1:0] KD_LOAD    = 2'd0;
  localparam logic [1:0] KD_RESTART = 2'd1;
  localparam logic [1:0] KD_QUERY   = 2'd2;

  // Key markers (code 3 behaves as a normal key)
  localparam logic [1:0] MK_NORMAL = 2'd0;
  localparam logic [1:0] MK_CTRL   = 2'd1;
  localparam logic [1:0] MK_END    = 2'd2;

  // Interpolation modes
  localparam logic [2:0] MD_STEP    = 3'd0;
  localparam logic [2:0] MD_LINEAR  = 3'd1;
  localparam logic [2:0] MD_SMOOTH  = 3'd2;
  localparam logic [2:0] MD_QUAD    = 3'd3;
  localparam logic [2:0] MD_TRIGGER = 3'd4;
  localparam logic [2:0] MD_EVENT   = 3'd5;
  localparam logic [2:0] MD_MAX     = 3'd7;

  // 1.0 in signed 4.12
  localparam logic signed [15:0] FX_ONE = 16'sd4096;

  typedef struct packed {
    logic [1:0]         marker;
    logic signed [15:0] frame;
    logic signed [15:0] value;
  } key_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         key_index;
    logic signed [15:0] frame;
    logic signed [15:0] key_value;
    logic [1:0]         key_marker;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] track_value;
  } out_item_t;

endpackage

FILE: rtl/core/kti_chan_if.sv
// Valid/ready channel carrying one item of type T.
interface kti_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/keyframe_track_interpolator.sv
// Keyframe track interpolator: key store, span walker, divider and mode datapath.
// Load writes the key store directly; restart runs one key-store advance.
// Query: reads the current span, runs one key-store advance per key walked past,
// then a last walk check, compute and output; linear, smoothstep and quadratic
// also wait on the 32-step bit-serial divider during compute.
// Synchronous active-low reset clears control state; the key store is not cleared.
module keyframe_track_interpolator #(
  parameter int KEY_DEPTH    = 256,
  parameter int SINE_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  kti_chan_if.sink   in_chan,
  kti_chan_if.source out_chan
);
  import kti_pkg::*;

  localparam int AW = $clog2(KEY_DEPTH);
  localparam int GW = $clog2(KEY_DEPTH + 1);
  localparam int SW = $clog2(SINE_ENTRIES);
  localparam logic signed [15:0] HALF_N = 16'(SINE_ENTRIES / 2);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ADV_A    = 4'd1;
  localparam logic [3:0] ST_ADV_B    = 4'd2;
  localparam logic [3:0] ST_ADV_C    = 4'd3;
  localparam logic [3:0] ST_Q_RD     = 4'd4;
  localparam logic [3:0] ST_Q_CHK    = 4'd5;
  localparam logic [3:0] ST_WALK     = 4'd6;
  localparam logic [3:0] ST_CALC     = 4'd7;
  localparam logic [3:0] ST_DIV_GO   = 4'd8;
  localparam logic [3:0] ST_DIV_WAIT = 4'd9;
  localparam logic [3:0] ST_COS      = 4'd10;
  localparam logic [3:0] ST_SQ       = 4'd11;
  localparam logic [3:0] ST_K        = 4'd12;
  localparam logic [3:0] ST_FIN      = 4'd13;
  localparam logic [3:0] ST_OUT      = 4'd14;

  function automatic logic [AW-1:0] inc_key(input logic [AW-1:0] c);
    return (c == AW'(KEY_DEPTH - 1)) ? '0 : c + 1'b1;
  endfunction

  logic [3:0]         state_r;
  logic [AW-1:0]      cur_key_r;
  logic [AW-1:0]      next_key_r;
  logic [2:0]         mode_r;
  logic signed [15:0] span_len_r;
  logic signed [15:0] span_dlt_r;
  logic               evt_pend_r;
  logic               quiet_r;
  logic               in_query_r;
  logic               skipped_r;
  logic [GW-1:0]      guard_r;
  logic signed [15:0] q_frame_r;
  logic signed [15:0] cur_f_r;
  logic signed [15:0] cur_v_r;
  logic signed [15:0] nxt_f_r;
  logic [1:0]         nxt_m_r;
  logic signed [31:0] mul_r;
  logic signed [15:0] quo_r;
  logic signed [15:0] res_r;
  logic               out_valid_r;
  logic signed [15:0] out_value_r;

  logic               in_fire;
  logic               out_free;
  logic [AW-1:0]      c1;
  logic [AW-1:0]      c2;
  logic               skip_w;
  logic               mem_we;
  logic               a_en;
  logic               b_en;
  logic [AW-1:0]      a_addr;
  logic [AW-1:0]      b_addr;
  key_t               q_a;
  key_t               q_b;
  key_t               wkey;
  logic signed [15:0] step_w;
  logic signed [15:0] trig_w;
  logic signed [15:0] mul_a;
  logic signed [15:0] mul_b;
  logic               div_start;
  logic               div_done;
  logic signed [15:0] div_q;
  logic               rom_en;
  logic [SW-1:0]      rom_addr;
  logic signed [15:0] rom_q;
  logic signed [16:0] kc_full;
  logic [2:0]         ctrl_mode;

  assign in_fire        = in_chan.valid && in_chan.ready;
  assign in_chan.ready  = (state_r == ST_IDLE);
  assign out_free       = !out_valid_r || out_chan.ready;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data.track_value = out_value_r;

  assign c1     = inc_key(cur_key_r);
  assign c2     = inc_key(c1);
  assign skip_w = !skipped_r && (q_a.marker == MK_CTRL);
  assign step_w = q_frame_r - cur_f_r;
  assign trig_w = cur_v_r - step_w;
  assign kc_full = 17'sd4096 - 17'(rom_q);
  assign ctrl_mode = ($unsigned(q_a.value) > 16'd7) ? MD_MAX : q_a.value[2:0];

  // key store write from a load item
  assign wkey.marker = in_chan.data.key_marker;
  assign wkey.frame  = in_chan.data.frame;
  assign wkey.value  = in_chan.data.key_value;
  assign mem_we = in_fire && (in_chan.data.kind == KD_LOAD) &&
                  (32'(in_chan.data.key_index) < KEY_DEPTH);

  // key store read requests
  always_comb begin
    a_en   = 1'b0;
    b_en   = 1'b0;
    a_addr = cur_key_r;
    b_addr = c1;
    unique case (state_r)
      ST_ADV_A: begin
        a_en = 1'b1;
        b_en = 1'b1;
      end
      ST_ADV_B: begin
        if (skip_w) begin
          a_en   = 1'b1;
          a_addr = c1;
          b_en   = 1'b1;
          b_addr = c2;
        end else if (q_b.marker == MK_CTRL) begin
          b_en   = 1'b1;
          b_addr = c2;
        end
      end
      ST_Q_RD: begin
        a_en   = 1'b1;
        b_en   = 1'b1;
        b_addr = next_key_r;
      end
      default: ;
    endcase
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CALC: begin
        mul_a = step_w;
        case (mode_r)
          MD_LINEAR: mul_b = span_dlt_r;
          MD_SMOOTH: mul_b = HALF_N;
          default:   mul_b = FX_ONE;
        endcase
      end
      ST_COS: begin
        mul_a = span_dlt_r;
        mul_b = kc_full[16:1];
      end
      ST_SQ: begin
        mul_a = quo_r;
        mul_b = quo_r;
      end
      ST_K: begin
        mul_a = span_dlt_r;
        mul_b = mul_r[27:12];
      end
      default: ;
    endcase
  end

  assign div_start = (state_r == ST_DIV_GO);
  assign rom_en    = (state_r == ST_DIV_WAIT) && div_done && (mode_r == MD_SMOOTH);
  assign rom_addr  = SW'(32'(div_q) + SINE_ENTRIES / 4);

  kti_keymem #(.KEY_DEPTH(KEY_DEPTH), .AW(AW)) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (AW'(in_chan.data.key_index)),
    .wdata  (wkey),
    .a_en   (a_en),
    .a_addr (a_addr),
    .b_en   (b_en),
    .b_addr (b_addr),
    .q_a    (q_a),
    .q_b    (q_b)
  );

  kti_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mul_r),
    .den   (span_len_r),
    .done  (div_done),
    .quo   (div_q)
  );

  kti_cos_rom #(.SINE_ENTRIES(SINE_ENTRIES), .SW(SW)) u_rom (
    .clk   (clk),
    .rd_en (rom_en),
    .addr  (rom_addr),
    .q     (rom_q)
  );

  // sequencer and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cur_key_r  <= '0;
      next_key_r <= '0;
      mode_r     <= MD_LINEAR;
      span_len_r <= '0;
      span_dlt_r <= '0;
      evt_pend_r <= 1'b1;
      in_query_r <= 1'b0;
      skipped_r  <= 1'b0;
      guard_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_chan.data.kind == KD_RESTART) begin
              mode_r     <= MD_LINEAR;
              evt_pend_r <= 1'b1;
              cur_key_r  <= '0;
              in_query_r <= 1'b0;
              state_r    <= ST_ADV_A;
            end else if (in_chan.data.kind == KD_QUERY) begin
              q_frame_r  <= in_chan.data.frame;
              in_query_r <= 1'b1;
              guard_r    <= '0;
              state_r    <= ST_Q_RD;
            end
          end
        end
        ST_ADV_A: begin
          skipped_r <= 1'b0;
          state_r   <= ST_ADV_B;
        end
        ST_ADV_B: begin
          if (skip_w) begin
            // control key: take its mode and move on one slot
            mode_r    <= ctrl_mode;
            cur_key_r <= c1;
            skipped_r <= 1'b1;
          end else if (q_b.marker == MK_CTRL) begin
            next_key_r <= c2;
            state_r    <= ST_ADV_C;
          end else begin
            next_key_r <= c1;
            state_r    <= ST_ADV_C;
          end
        end
        ST_ADV_C: begin
          // span setup from current and next key
          cur_f_r <= q_a.frame;
          cur_v_r <= q_a.value;
          nxt_f_r <= q_b.frame;
          nxt_m_r <= q_b.marker;
          if (q_b.marker != MK_END) begin
            span_len_r <= q_b.frame - q_a.frame;
            span_dlt_r <= q_b.value - q_a.value;
            evt_pend_r <= 1'b1;
          end
          state_r <= in_query_r ? ST_WALK : ST_IDLE;
        end
        ST_Q_RD: begin
          quiet_r <= (mode_r == MD_TRIGGER) || (mode_r == MD_EVENT);
          state_r <= ST_Q_CHK;
        end
        ST_Q_CHK: begin
          cur_f_r <= q_a.frame;
          cur_v_r <= q_a.value;
          nxt_f_r <= q_b.frame;
          nxt_m_r <= q_b.marker;
          if (q_frame_r < q_a.frame) begin
            res_r   <= quiet_r ? 16'sd0 : q_a.value;
            state_r <= ST_OUT;
          end else if (q_b.marker == MK_END) begin
            if (quiet_r) begin
              state_r <= ST_CALC;
            end else begin
              res_r   <= q_a.value;
              state_r <= ST_OUT;
            end
          end else begin
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (nxt_m_r == MK_END) begin
            res_r   <= cur_v_r;
            state_r <= ST_OUT;
          end else if ((q_frame_r >= nxt_f_r) && (32'(guard_r) < KEY_DEPTH)) begin
            guard_r   <= guard_r + 1'b1;
            cur_key_r <= c1;
            state_r   <= ST_ADV_A;
          end else begin
            state_r <= ST_CALC;
          end
        end
        ST_CALC: begin
          mul_r <= mul_a * mul_b;
          case (mode_r) inside
            MD_LINEAR, MD_SMOOTH, MD_QUAD: state_r <= ST_DIV_GO;
            MD_STEP: begin
              res_r   <= cur_v_r;
              state_r <= ST_OUT;
            end
            MD_TRIGGER: begin
              res_r   <= (trig_w > 16'sd0) ? trig_w : 16'sd0;
              state_r <= ST_OUT;
            end
            MD_EVENT: begin
              res_r      <= evt_pend_r ? cur_v_r : 16'sd0;
              evt_pend_r <= 1'b0;
              state_r    <= ST_OUT;
            end
            default: begin
              res_r   <= '0;
              state_r <= ST_OUT;
            end
          endcase
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            quo_r <= div_q;
            if (mode_r == MD_LINEAR) begin
              res_r   <= cur_v_r + div_q;
              state_r <= ST_OUT;
            end else if (mode_r == MD_SMOOTH) begin
              state_r <= ST_COS;
            end else begin
              state_r <= ST_SQ;
            end
          end
        end
        ST_COS: begin
          mul_r   <= mul_a * mul_b;
          state_r <= ST_FIN;
        end
        ST_SQ: begin
          mul_r   <= mul_a * mul_b;
          state_r <= ST_K;
        end
        ST_K: begin
          mul_r   <= mul_a * mul_b;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          res_r   <= cur_v_r + mul_r[27:12];
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_OUT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_OUT) && out_free) begin
      out_value_r <= res_r;
    end
  end

`ifndef SYNTHESIS
  a_guard_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(guard_r) <= KEY_DEPTH)
    else $error("walk guard exceeded key depth");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_adv_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADV_A |=> state_r == ST_ADV_B)
    else $error("advance read not followed by its check");
`endif

endmodule

FILE: rtl/core/kti_keymem.sv
// Key store: one write port, two registered read ports.
module kti_keymem #(
  parameter int KEY_DEPTH = 256,
  parameter int AW        = 8
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  kti_pkg::key_t   wdata,
  input  logic            a_en,
  input  logic [AW-1:0]   a_addr,
  input  logic            b_en,
  input  logic [AW-1:0]   b_addr,
  output kti_pkg::key_t   q_a,
  output kti_pkg::key_t   q_b
);
  import kti_pkg::*;

  key_t mem [KEY_DEPTH];
  key_t qa_r;
  key_t qb_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports hold their data when not enabled
  always_ff @(posedge clk) begin
    if (a_en) begin
      qa_r <= mem[a_addr];
    end
    if (b_en) begin
      qb_r <= mem[b_addr];
    end
  end

  assign q_a = qa_r;
  assign q_b = qb_r;

endmodule

FILE: rtl/core/kti_div.sv
// Bit-serial signed divider, 32 by 16, truncating, quotient saturated to 16 bits.
module kti_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [15:0] den,
  output logic               done,
  output logic signed [15:0] quo
);
  logic [31:0] sh_r;
  logic [16:0] rem_r;
  logic [15:0] den_r;
  logic        neg_r;
  logic        dz_r;
  logic        busy_r;
  logic        done_r;
  logic [4:0]  cnt_r;
  logic [16:0] rem_sh;
  logic        ge;

  // one quotient bit per cycle
  assign rem_sh = {rem_r[15:0], sh_r[31]};
  assign ge     = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= num[31] ? 32'(-num) : num;
      den_r <= den[15] ? 16'(-den) : den;
      rem_r <= '0;
      neg_r <= num[31] ^ den[15];
      dz_r  <= (den == 16'sd0);
    end else if (busy_r) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      sh_r  <= {sh_r[30:0], ge};
    end
  end

  // sign and saturation
  always_comb begin
    if (dz_r) begin
      quo = '0;
    end else if (!neg_r) begin
      quo = (sh_r > 32'd32767) ? 16'sh7FFF : sh_r[15:0];
    end else begin
      quo = (sh_r > 32'd32768) ? 16'sh8000 : 16'(-sh_r[15:0]);
    end
  end

  assign done = done_r;

endmodule

FILE: rtl/core/kti_cos_rom.sv
// Sine table built at elaboration, read through a registered output.
module kti_cos_rom #(
  parameter int SINE_ENTRIES = 4096,
  parameter int SW           = 12
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [SW-1:0]       addr,
  output logic signed [15:0]  q
);
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Taylor series to x^15 on a first-quadrant angle in 2.30
  function automatic logic signed [15:0] sine_at(input int i);
    logic [63:0]        th;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic               neg;
    logic [63:0]        v;
    th  = (64'(i) * TWO_PI_Q30) / SINE_ENTRIES;
    neg = 1'b0;
    if (th >= PI_Q30) begin
      neg = 1'b1;
      th  = th - PI_Q30;
    end
    if (th > HALF_PI_Q30) begin
      th = PI_Q30 - th;
    end
    x2   = (th * th) >> 30;
    sum  = $signed(th);
    term = ((th * x2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + $signed(term);
    term = ((term * x2) >> 30) / 210;
    sum  = sum - $signed(term);
    if (sum < 0) begin
      sum = 0;
    end
    v = ($unsigned(sum) + 64'd131072) >> 18;
    return neg ? 16'(-v) : 16'(v);
  endfunction

  logic signed [15:0] tbl [SINE_ENTRIES];
  logic signed [15:0] q_r;

  for (genvar g = 0; g < SINE_ENTRIES; g++) begin : g_tbl
    assign tbl[g] = sine_at(g);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_r <= tbl[addr];
    end
  end

  assign q = q_r;

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the keyframe track interpolator.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import kti_pkg::*;

  localparam int DEPTH       = 256;
  localparam int SINE_N      = 4096;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int N_ITEMS     = 1600;

  logic clk;
  logic rst_n;

  kti_chan_if #(.T(in_item_t))  in_if ();
  kti_chan_if #(.T(out_item_t)) out_if ();

  keyframe_track_interpolator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // Clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Track model state
  key_t        track_keys [DEPTH];
  int          cur_slot, nxt_slot;
  logic [2:0]  interp_mode;
  int          span_len, span_dlt;
  bit          evt_pending;
  int          cos_rom [SINE_N];

  logic signed [15:0] track_values_q [$];

  int  n_errors;
  int  n_sent;
  int  n_checked;
  int  cycles;
  bit  no_idle;
  bit [7:0] modes_hit;

  function automatic int wrap16(int x);
    logic signed [15:0] w;
    w = x[15:0];
    return int'(w);
  endfunction

  function automatic int div_sat(int num, int den);
    longint q;
    if (den == 0) return 0;
    q = longint'(num) / longint'(den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  // Sine table in 4.12, Taylor series on a 2.30 angle
  function automatic void build_sine();
    longint unsigned th, x2, term;
    longint sum;
    int v;
    bit neg;
    for (int i = 0; i < SINE_N; i++) begin
      th = longint'(i) * 64'd6746518852 / SINE_N;
      neg = 1'b0;
      if (th >= 64'd3373259426) begin
        neg = 1'b1;
        th -= 64'd3373259426;
      end
      if (th > 64'd1686629713) th = 64'd3373259426 - th;
      x2 = (th * th) >> 30;
      term = th;
      sum = longint'(th);
      for (int k = 1; k <= 7; k++) begin
        term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      v = int'((longint'(sum) + 131072) >>> 18);
      cos_rom[i] = neg ? -v : v;
    end
  endfunction

  function automatic void move_to(int c);
    int n;
    c = c % DEPTH;
    if (track_keys[c].marker == MK_CTRL) begin
      interp_mode = (track_keys[c].value < 0 || track_keys[c].value > 7) ?
                    MD_MAX : track_keys[c].value[2:0];
      c = (c + 1) % DEPTH;
    end
    cur_slot = c;
    n = (c + 1) % DEPTH;
    if (track_keys[n].marker == MK_CTRL) n = (n + 1) % DEPTH;
    nxt_slot = n;
    if (track_keys[n].marker != MK_END) begin
      span_len = wrap16(int'(track_keys[n].frame) - int'(track_keys[c].frame));
      span_dlt = wrap16(int'(track_keys[n].value) - int'(track_keys[c].value));
      evt_pending = 1'b1;
    end
  endfunction

  function automatic int eval_frame(int f);
    bit quiet;
    int guard, step, t, k, idx, v;
    quiet = (interp_mode == MD_TRIGGER) || (interp_mode == MD_EVENT);
    if (f < int'(track_keys[cur_slot].frame))
      return quiet ? 0 : int'(track_keys[cur_slot].value);
    if (track_keys[nxt_slot].marker == MK_END) begin
      if (!quiet) return int'(track_keys[cur_slot].value);
    end else begin
      guard = 0;
      while (f >= int'(track_keys[nxt_slot].frame) && guard < DEPTH) begin
        move_to(cur_slot + 1);
        guard++;
        if (track_keys[nxt_slot].marker == MK_END)
          return int'(track_keys[cur_slot].value);
      end
    end
    modes_hit[interp_mode] = 1'b1;
    step = wrap16(f - int'(track_keys[cur_slot].frame));
    v = int'(track_keys[cur_slot].value);
    case (interp_mode)
      MD_STEP:   return v;
      MD_LINEAR: return wrap16(v + div_sat(step * span_dlt, span_len));
      MD_SMOOTH: begin
        t = div_sat(step * (SINE_N / 2), span_len);
        idx = (t + SINE_N / 4) % SINE_N;
        if (idx < 0) idx += SINE_N;
        k = (int'(FX_ONE) - cos_rom[idx]) / 2;
        return wrap16(v + wrap16((span_dlt * k) >>> 12));
      end
      MD_QUAD: begin
        t = div_sat(step * int'(FX_ONE), span_len);
        k = wrap16((t * t) >>> 12);
        return wrap16(v + wrap16((span_dlt * k) >>> 12));
      end
      MD_TRIGGER: begin
        t = wrap16(v - step);
        return t > 0 ? t : 0;
      end
      MD_EVENT: begin
        if (!evt_pending) return 0;
        evt_pending = 1'b0;
        return v;
      end
      default:   return 0;
    endcase
  endfunction

  // Update the model for an accepted item and queue any expected value
  function automatic void apply_item(in_item_t it, bit typed, shortint typed_val);
    int r;
    case (it.kind)
      KD_LOAD: begin
        track_keys[it.key_index].frame  = it.frame;
        track_keys[it.key_index].value  = it.key_value;
        track_keys[it.key_index].marker = it.key_marker;
      end
      KD_RESTART: begin
        interp_mode = MD_LINEAR;
        evt_pending = 1'b1;
        move_to(0);
      end
      KD_QUERY: begin
        r = eval_frame(int'(it.frame));
        track_values_q.push_back(typed ? typed_val : r[15:0]);
      end
      default: ;
    endcase
  endfunction

  // Send one item, with random idle cycles in front
  task automatic send_item(in_item_t it, bit typed, shortint typed_val);
    while (!no_idle && $urandom_range(99) < 32) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    @(negedge clk);
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do @(posedge clk); while (!in_if.ready);
    apply_item(it, typed, typed_val);
    if (it.kind != 2'd3) n_sent++;
  endtask

  function automatic in_item_t mk(logic [1:0] kd, logic [7:0] ix, shortint f, shortint v,
                                  logic [1:0] mkr);
    in_item_t it;
    it.kind = kd;
    it.key_index = ix;
    it.frame = f;
    it.key_value = v;
    it.key_marker = mkr;
    return it;
  endfunction

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (track_values_q.size() == 0) begin
        $error("unexpected result track_value=%0d", out_if.data.track_value);
        n_errors++;
      end else begin
        if (out_if.data.track_value !== track_values_q[0]) begin
          $error("track_value mismatch: expected %0d, actual %0d",
                 track_values_q[0], out_if.data.track_value);
          n_errors++;
        end
        void'(track_values_q.pop_front());
        n_checked++;
      end
    end
  end

  // Result-side stalls
  always @(negedge clk) begin
    out_if.ready <= no_idle || ($urandom_range(99) >= 32);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  typedef struct {
    in_item_t it;
    bit       typed;
    shortint  val;
  } stim_row_t;

  stim_row_t directed [$];

  // Write a short well-formed track from slot 0, rewind it, then play it back
  task automatic play_track();
    int n_keys, slot, f, q_frames, qf;
    bit has_ctrl;
    shortint v;
    n_keys = $urandom_range(2, 10);
    slot = 0;
    f = $urandom_range(0, 3) == 0 ? int'($urandom_range(65535)) - 32768 :
        int'($urandom_range(200)) - 100;
    for (int j = 0; j < n_keys; j++) begin
      has_ctrl = ($urandom_range(3) == 0);
      if (has_ctrl) begin
        v = ($urandom_range(7) == 0) ? shortint'($urandom) :
            shortint'($urandom_range(7));
        send_item(mk(KD_LOAD, slot[7:0], shortint'($urandom), v, MK_CTRL), 0, 0);
        slot++;
      end
      v = ($urandom_range(1) == 0) ? shortint'($urandom) :
          shortint'(int'($urandom_range(2000)) - 1000);
      send_item(mk(KD_LOAD, slot[7:0], shortint'(f), v,
                   ($urandom_range(9) == 0) ? 2'd3 : MK_NORMAL), 0, 0);
      slot++;
      f += $urandom_range(0, 40);
      if (f > 32767) f = 32767;
    end
    if ($urandom_range(4) != 0)
      send_item(mk(KD_LOAD, slot[7:0], shortint'(f), shortint'($urandom), MK_END), 0, 0);
    send_item(mk(KD_RESTART, 8'($urandom), shortint'($urandom), shortint'($urandom),
                 2'($urandom)), 0, 0);
    q_frames = $urandom_range(3, 12);
    qf = int'(track_keys[cur_slot].frame) - 5;
    for (int j = 0; j < q_frames; j++) begin
      if ($urandom_range(9) == 0) qf = int'($urandom_range(65535)) - 32768;
      else qf += $urandom_range(0, 20);
      if (qf > 32767) qf = 32767;
      send_item(mk(KD_QUERY, 8'($urandom), shortint'(qf), shortint'($urandom),
                   2'($urandom)), 0, 0);
    end
  endtask

  initial begin
    int settle;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    cycles = 0;
    no_idle = 1'b0;
    modes_hit = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    build_sine();
    for (int i = 0; i < DEPTH; i++) track_keys[i] = '0;
    cur_slot = 0;
    nxt_slot = 0;
    interp_mode = MD_LINEAR;
    span_len = 0;
    span_dlt = 0;
    evt_pending = 1'b1;

    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every slot: frame 16*i, value 64*i, last slot is an end key
    for (int i = 0; i < DEPTH; i++)
      send_item(mk(KD_LOAD, i[7:0], shortint'(i * 16), shortint'(i * 64),
                   (i == DEPTH - 1) ? MK_END : MK_NORMAL), 0, 0);

    // Directed rows
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, -16'sd32768, 0, 0), 1, 0});
    directed.push_back('{mk(KD_QUERY, 0, 8, 0, 0), 1, 32});
    directed.push_back('{mk(KD_LOAD, 1, 16, MD_STEP, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 40, 0, 0), 1, 128});
    directed.push_back('{mk(KD_QUERY, 0, 16'sd32767, 0, 0), 1, 16256});
    directed.push_back('{mk(KD_QUERY, 0, 16'sd32767, 0, 0), 1, 16256});
    directed.push_back('{mk(KD_LOAD, 1, 16, MD_SMOOTH, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 40, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 50, 0, 0), 0, 0});
    directed.push_back('{mk(KD_LOAD, 1, 16, MD_QUAD, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 50, 0, 0), 0, 0});
    directed.push_back('{mk(KD_LOAD, 1, 16, MD_TRIGGER, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 40, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, -5, 0, 0), 1, 0});
    directed.push_back('{mk(KD_LOAD, 1, 16, MD_EVENT, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 40, 0, 0), 1, 128});
    directed.push_back('{mk(KD_QUERY, 0, 41, 0, 0), 1, 0});
    // Out-of-range control value selects the null mode
    directed.push_back('{mk(KD_LOAD, 1, 16, -16'sd1, MK_CTRL), 0, 0});
    directed.push_back('{mk(KD_RESTART, 0, 0, 0, 0), 0, 0});
    directed.push_back('{mk(KD_QUERY, 0, 40, 0, 0), 1, 0});
    // Value extremes, marker code 3, unused kind
    directed.push_back('{mk(KD_LOAD, 3, 48, 16'sd32767, 2'd3), 0, 0});
    directed.push_back('{mk(KD_LOAD, 8'hFF, -16'sd32768, -16'sd32768, MK_END), 0, 0});
    directed.push_back('{mk(2'd3, 8'hFF, -1, -1, 2'd3), 0, 0});
    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].val);

    // Random part: mostly well-formed tracks, some noise
    while (n_sent < N_ITEMS) begin
      no_idle = (n_sent > 700 && n_sent < 950);
      if ($urandom_range(99) < 80) play_track();
      else send_item(mk(2'($urandom), 8'($urandom), shortint'($urandom),
                        shortint'($urandom), 2'($urandom)), 0, 0);
    end
    @(negedge clk);
    in_if.valid <= 1'b0;

    // Drain, then allow an item with no result to finish
    while (track_values_q.size() != 0) @(posedge clk);
    settle = 0;
    while (settle < 100) begin
      @(posedge clk);
      settle++;
    end

    $display("Sent %0d items, checked %0d track values", n_sent, n_checked);
    $display("Interpolation modes exercised (bit per mode): %b", modes_hit);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
